[rtl/core/bti_pkg.sv]
// Shared types and constants of the bilinear table interpolator.
`timescale 1ns / 1ps
package bti_pkg;

  localparam int WORD_W   = 32;
  localparam int PORT_IDX_W = 5;
  localparam int CFG_W    = 5;
  localparam int QUO_W    = 16;
  localparam int FRAC_W   = QUO_W + 1;
  localparam int DIV_W    = WORD_W + 1;
  localparam int CORN_W   = WORD_W + QUO_W + 1;
  localparam int MUL_A_W  = CORN_W + 1;
  localparam int MUL_P_W  = MUL_A_W + FRAC_W;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << QUO_W;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    MUL_C1 = 2'd0,
    MUL_C2 = 2'd1,
    MUL_S  = 2'd2
  } mul_sel_e;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CLAMP  = 8'b0000_0010,
    S_SRCH   = 8'b0000_0100,
    S_EDGE   = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_CORNER = 8'b0010_0000,
    S_MUL    = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

[rtl/core/bti_divider.sv]
// Restoring divider, one quotient bit per cycle, for the Q0.16 axis fraction.
`timescale 1ns / 1ps
module bti_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bti_pkg::DIV_W-1:0]  num_i,
  input  logic [bti_pkg::DIV_W-1:0]  den_i,
  output logic                       done_o,
  output logic [bti_pkg::QUO_W-1:0]  quo_o
);
  import bti_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DIV_W-1:0] rem_q, rem_d, den_q;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DIV_W:0]   r2;
  logic [DIV_W:0]   diff;

  assign r2   = {rem_q, 1'b0};
  assign diff = r2 - {1'b0, den_q};

  always_comb begin
    if (r2 >= {1'b0, den_q}) begin
      rem_d = diff[DIV_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], 1'b1};
    end else begin
      rem_d = r2[DIV_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QUO_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/core/bti_multiplier.sv]
// Shift-add multiplier: signed multiplicand by unsigned Q1.16 weight, one bit per cycle.
`timescale 1ns / 1ps
module bti_multiplier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [bti_pkg::MUL_A_W-1:0] a_i,
  input  logic [bti_pkg::FRAC_W-1:0]         b_i,
  output logic                               done_o,
  output logic signed [bti_pkg::MUL_P_W-1:0] prod_o
);
  import bti_pkg::*;

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic signed [MUL_P_W-1:0] acc_q, mcand_q;
  logic [FRAC_W-1:0]         mplier_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(FRAC_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= MUL_P_W'(a_i);
      mplier_q <= b_i;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= mcand_q <<< 1;
      mplier_q <= mplier_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

[rtl/core/bilinear_table_interpolator.sv]
// Top level: table memory, query sequencer and the shared divider and multiplier.
// Table write beat: accepted while idle, no result; the block stays ready.
// Query beat: from accept to result valid the sequencer runs the clamp reads, two binary
// searches, two divides skipped when the fraction is 0 or one, and three multiplies;
// ready is low until the result is loaded.
// Async active-low reset clears control and sets points_in_use to 2; table is not cleared.
`timescale 1ns / 1ps
module bilinear_table_interpolator #(
  parameter int MAX_POINTS = 31
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [bti_pkg::CFG_W-1:0]               cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic                                    cmd_i,
  input  logic [bti_pkg::PORT_IDX_W-1:0]          row_index_i,
  input  logic [bti_pkg::PORT_IDX_W-1:0]          column_index_i,
  input  logic signed [bti_pkg::WORD_W-1:0]       table_word_i,
  input  logic signed [bti_pkg::WORD_W-1:0]       query_pressure_i,
  input  logic signed [bti_pkg::WORD_W-1:0]       query_temperature_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [bti_pkg::WORD_W-1:0]       interpolated_value_o
);
  import bti_pkg::*;

  localparam int IW    = $clog2(MAX_POINTS + 1);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;

  logic [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rdata_q;
  logic [IW-1:0] rd_r, rd_c;

  state_e   state_q;
  logic     ph_q, axis_q;
  logic [1:0] sub_q;
  mul_sel_e msel_q;
  logic [CFG_W-1:0] cfg_q;
  logic [IW-1:0] n_q, lo_q, hi_q, i_q, j_q, mid, base, n_eff;
  logic signed [WORD_W-1:0] p_q, t_q, alo_q, ahi_q, vlo_q, vhi_q, x_sel, res_q;
  logic [FRAC_W-1:0] fp_q, ft_q, frac_new;
  logic signed [CORN_W-1:0] c1_q, c2_q;
  logic out_valid_q;
  logic wr_en, q_acc, srch_end, frac_sel, fin_load;

  logic signed [DIV_W-1:0] num, den;
  logic signed [DIV_W-1:0] diff_v;
  logic signed [MUL_A_W-1:0] diff_c, mul_a;
  logic [FRAC_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod, lo_ext, sum, rnd;
  logic [QUO_W-1:0] quo;
  unit_ctl_t div_ctl, mul_ctl;

  assign in_ready_o = (state_q == S_IDLE);
  assign wr_en = in_valid_i && in_ready_o && (cmd_i == CMD_WRITE)
              && (int'(row_index_i) <= MAX_POINTS) && (int'(column_index_i) <= MAX_POINTS);
  assign q_acc = in_valid_i && in_ready_o && (cmd_i == CMD_QUERY);
  assign fin_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    if (cfg_q < CFG_W'(2)) begin
      n_eff = IW'(2);
    end else if (int'(cfg_q) > MAX_POINTS) begin
      n_eff = IW'(MAX_POINTS);
    end else begin
      n_eff = IW'(cfg_q);
    end
  end

  assign mid      = IW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
  assign srch_end = ({1'b0, hi_q} <= ({1'b0, lo_q} + 1'b1));
  assign x_sel    = axis_q ? t_q : p_q;
  assign base     = axis_q ? j_q : i_q;

  always_comb begin
    rd_r = '0;
    rd_c = '0;
    case (state_q)
      S_CLAMP: begin
        case (sub_q)
          2'd0:    rd_r = IW'(1);
          2'd1:    rd_r = n_q;
          2'd2:    rd_c = IW'(1);
          default: rd_c = n_q;
        endcase
      end
      S_SRCH: begin
        if (axis_q) rd_c = mid;
        else rd_r = mid;
      end
      S_EDGE: begin
        if (axis_q) rd_c = base + IW'(sub_q[0]);
        else rd_r = base + IW'(sub_q[0]);
      end
      S_CORNER: begin
        rd_r = i_q + IW'(sub_q[0]);
        rd_c = j_q + IW'(sub_q[1]);
      end
      default: begin
        rd_r = '0;
        rd_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[{IW'(row_index_i), IW'(column_index_i)}] <= table_word_i;
    end
    rdata_q <= mem[{rd_r, rd_c}];
  end

  assign num = {x_sel[WORD_W-1], x_sel} - {alo_q[WORD_W-1], alo_q};
  assign den = {ahi_q[WORD_W-1], ahi_q} - {alo_q[WORD_W-1], alo_q};

  assign diff_v = {vhi_q[WORD_W-1], vhi_q} - {vlo_q[WORD_W-1], vlo_q};
  assign diff_c = {c2_q[CORN_W-1], c2_q} - {c1_q[CORN_W-1], c1_q};
  assign mul_a  = (msel_q == MUL_S) ? diff_c : MUL_A_W'(diff_v);
  assign mul_b  = (msel_q == MUL_S) ? ft_q : fp_q;

  assign lo_ext = (msel_q == MUL_S) ? {{2{c1_q[CORN_W-1]}}, c1_q, {QUO_W{1'b0}}}
                                    : {{19{vlo_q[WORD_W-1]}}, vlo_q, {QUO_W{1'b0}}};
  assign sum = lo_ext + prod;
  assign rnd = sum + (MUL_P_W'(1) <<< 31);

  assign frac_sel = (den <= 0) || (num <= 0);
  assign frac_new = frac_sel ? '0 : FRAC_ONE;

  assign div_ctl.start = (state_q == S_DIV) && !ph_q && !frac_sel && (num < den);
  assign mul_ctl.start = (state_q == S_MUL) && !ph_q;

  bti_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_ctl.start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_ctl.done),
    .quo_o   (quo)
  );

  bti_multiplier u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_ctl.start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_ctl.done),
    .prod_o  (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_W'(2);
      state_q     <= S_IDLE;
      ph_q        <= 1'b0;
      axis_q      <= 1'b0;
      sub_q       <= '0;
      msel_q      <= MUL_C1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      if (fin_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (q_acc) begin
            state_q <= S_CLAMP;
            sub_q   <= '0;
            ph_q    <= 1'b0;
          end
        end
        S_CLAMP: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            sub_q <= sub_q + 1'b1;
            if (sub_q == 2'd3) begin
              state_q <= S_SRCH;
              axis_q  <= 1'b0;
            end
          end
        end
        S_SRCH: begin
          if (!ph_q) begin
            if (srch_end) begin
              if (axis_q) begin
                state_q <= S_EDGE;
                axis_q  <= 1'b0;
                sub_q   <= '0;
              end else begin
                axis_q <= 1'b1;
              end
            end else begin
              ph_q <= 1'b1;
            end
          end else begin
            ph_q <= 1'b0;
          end
        end
        S_EDGE: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            sub_q <= sub_q + 1'b1;
            if (sub_q[0]) begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if ((!ph_q && !div_ctl.start) || (ph_q && div_ctl.done)) begin
            ph_q  <= 1'b0;
            sub_q <= '0;
            if (axis_q) begin
              state_q <= S_CORNER;
            end else begin
              state_q <= S_EDGE;
              axis_q  <= 1'b1;
            end
          end else if (!ph_q) begin
            ph_q <= 1'b1;
          end
        end
        S_CORNER: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            sub_q <= sub_q + 1'b1;
            if (sub_q[0]) begin
              state_q <= S_MUL;
              msel_q  <= sub_q[1] ? MUL_C2 : MUL_C1;
            end
          end
        end
        S_MUL: begin
          if (!ph_q) begin
            ph_q <= 1'b1;
          end else if (mul_ctl.done) begin
            ph_q <= 1'b0;
            case (msel_q)
              MUL_C1:  state_q <= S_CORNER;
              MUL_C2:  msel_q <= MUL_S;
              default: state_q <= S_FIN;
            endcase
          end
        end
        S_FIN: begin
          if (fin_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_acc) begin
      n_q <= n_eff;
      p_q <= query_pressure_i;
      t_q <= query_temperature_i;
    end
    case (state_q)
      S_CLAMP: begin
        if (ph_q) begin
          case (sub_q)
            2'd0:    if (p_q < rdata_q) p_q <= rdata_q;
            2'd1:    if (p_q >= rdata_q) p_q <= rdata_q;
            2'd2:    if (t_q < rdata_q) t_q <= rdata_q;
            default: begin
              if (t_q >= rdata_q) t_q <= rdata_q;
              lo_q <= IW'(1);
              hi_q <= n_q;
            end
          endcase
        end
      end
      S_SRCH: begin
        if (!ph_q) begin
          if (srch_end) begin
            if (axis_q) j_q <= lo_q;
            else i_q <= lo_q;
            lo_q <= IW'(1);
            hi_q <= n_q;
          end
        end else begin
          if (rdata_q <= x_sel) lo_q <= mid;
          else hi_q <= mid;
        end
      end
      S_EDGE: begin
        if (ph_q) begin
          if (sub_q[0]) ahi_q <= rdata_q;
          else alo_q <= rdata_q;
        end
      end
      S_DIV: begin
        if (!ph_q && !div_ctl.start) begin
          if (axis_q) ft_q <= frac_new;
          else fp_q <= frac_new;
        end else if (ph_q && div_ctl.done) begin
          if (axis_q) ft_q <= {1'b0, quo};
          else fp_q <= {1'b0, quo};
        end
      end
      S_CORNER: begin
        if (ph_q) begin
          if (sub_q[0]) vhi_q <= rdata_q;
          else vlo_q <= rdata_q;
        end
      end
      S_MUL: begin
        if (ph_q && mul_ctl.done) begin
          case (msel_q)
            MUL_C1:  c1_q <= sum[CORN_W-1:0];
            MUL_C2:  c2_q <= sum[CORN_W-1:0];
            default: ;
          endcase
        end
      end
      S_FIN: begin
        if (fin_load) res_q <= rnd[63:32];
      end
      default: ;
    endcase
  end

  assign out_valid_o          = out_valid_q;
  assign interpolated_value_o = res_q;

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.done |-> (state_q == S_DIV) && ph_q)
    else $error("divider finished outside the divide step");

  a_mul_only_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_ctl.done |-> (state_q == S_MUL) && ph_q)
    else $error("multiplier finished outside the multiply step");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> (lo_q < hi_q) && (hi_q <= n_q))
    else $error("search bracket out of order");

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && !out_valid_q |=> out_valid_q && in_ready_o)
    else $error("result not loaded at finish");

endmodule

[tb/bilinear_table_interpolator_tb.sv]
// Testbench: table load and bilinear query checking against a built-in predictor.
`timescale 1ns / 1ps
module bilinear_table_interpolator_tb;
  import bti_pkg::*;

  typedef struct {
    logic              cmd;
    logic [4:0]        row;
    logic [4:0]        col;
    logic [31:0]       word;
    logic [31:0]       pres;
    logic [31:0]       temp;
    bit                known;
    logic [31:0]       value;
  } beat_t;

  logic clk_i, rst_ni, cfg_we_i, in_valid_i, cmd_i, out_ready_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic [PORT_IDX_W-1:0] row_index_i, column_index_i;
  logic signed [WORD_W-1:0] table_word_i, query_pressure_i, query_temperature_i;
  logic in_ready_o, out_valid_o;
  logic signed [WORD_W-1:0] interpolated_value_o;

  logic signed [31:0] table_copy [32][32];
  bit written [32][32];
  int unsigned points_reg;
  logic [31:0] interp_queue [$];
  int errors, items;
  bit idle_en;

  bilinear_table_interpolator uut (.*);

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint blend_frac(longint x, longint lo, longint hi);
    longint num, den;
    num = x - lo;
    den = hi - lo;
    if (den <= 0 || num <= 0) return 0;
    if (num >= den) return 65536;
    return (num <<< 16) / den;
  endfunction

  function automatic int unsigned bracket(bit temp_axis, int unsigned n, longint x);
    int unsigned lo, hi, mid;
    longint a;
    lo = 1;
    hi = n;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      a = temp_axis ? table_copy[0][mid] : table_copy[mid][0];
      if (a <= x) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [31:0] interpolate(logic signed [31:0] pres, logic signed [31:0] temp);
    int unsigned n, i, j;
    longint p, t, fp, ft, c1, c2, s;
    logic [63:0] u;
    n = points_reg < 2 ? 2 : (points_reg > 31 ? 31 : points_reg);
    p = pres;
    t = temp;
    if (p < longint'(table_copy[1][0])) p = table_copy[1][0];
    if (p >= longint'(table_copy[n][0])) p = table_copy[n][0];
    if (t < longint'(table_copy[0][1])) t = table_copy[0][1];
    if (t >= longint'(table_copy[0][n])) t = table_copy[0][n];
    i = bracket(0, n, p);
    j = bracket(1, n, t);
    fp = blend_frac(p, table_copy[i][0], table_copy[i+1][0]);
    ft = blend_frac(t, table_copy[0][j], table_copy[0][j+1]);
    c1 = longint'(table_copy[i][j]) * (65536 - fp) + longint'(table_copy[i+1][j]) * fp;
    c2 = longint'(table_copy[i][j+1]) * (65536 - fp) + longint'(table_copy[i+1][j+1]) * fp;
    s = c1 * (65536 - ft) + c2 * ft;
    u = 64'(s) + 64'h8000_0000_0000_0000 + 64'h8000_0000;
    return u[63:32] ^ 32'h8000_0000;
  endfunction

  task automatic send(beat_t b);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= b.cmd;
    row_index_i <= b.row;
    column_index_i <= b.col;
    table_word_i <= b.word;
    query_pressure_i <= b.pres;
    query_temperature_i <= b.temp;
    do @(posedge clk_i); while (!in_ready_o);
    items++;
    if (b.cmd == CMD_WRITE) begin
      table_copy[b.row][b.col] = b.word;
      written[b.row][b.col] = 1;
    end else begin
      interp_queue.push_back(b.known ? b.value : interpolate(b.pres, b.temp));
    end
  endtask

  task automatic put_word(int r, int c, logic [31:0] w);
    beat_t b;
    b = '{CMD_WRITE, 5'(r), 5'(c), w, $urandom, $urandom, 0, 0};
    send(b);
  endtask

  task automatic set_points(int unsigned v);
    in_valid_i <= 1'b0;
    wait (interp_queue.size() == 0);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CFG_W'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    points_reg = v;
  endtask

  task automatic load_axis(bit temp_axis, int n);
    int q [$];
    int mode;
    mode = $urandom_range(0, 5);
    for (int k = 0; k < n; k++) begin
      if (mode == 1) q.push_back($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      else q.push_back($urandom);
    end
    if (mode == 2) begin
      q[0] = 32'h8000_0000;
      q[n-1] = 32'h7fff_ffff;
    end
    if (mode == 3)
      for (int k = 1; k < n; k++) if ($urandom_range(0, 2) == 0) q[k] = q[k-1];
    if (mode != 4) q.sort();
    if (mode == 5) for (int k = 0; k < n; k++) q[k] = q[0];
    for (int k = 0; k < n; k++)
      if (temp_axis) put_word(0, k + 1, q[k]);
      else put_word(k + 1, 0, q[k]);
  endtask

  function automatic logic [31:0] pick_coord(bit temp_axis, int n);
    int k;
    logic signed [31:0] a, b;
    k = $urandom_range(1, n);
    a = temp_axis ? table_copy[0][k] : table_copy[k][0];
    b = temp_axis ? table_copy[0][k < n ? k + 1 : k] : table_copy[k < n ? k + 1 : k][0];
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3, 4: return a;
      default: return 32'(longint'(a) + (longint'(b) - longint'(a))
                          * longint'(int'($urandom_range(0, 1000))) / 1000);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (interp_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %h", $time, interpolated_value_o);
      end else begin
        if (interpolated_value_o !== interp_queue[0]) begin
          errors++;
          $display("%0t: interpolated_value expected %h actual %h", $time,
                   interp_queue[0], interpolated_value_o);
        end
        interp_queue.pop_front();
      end
    end
  end

  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      if (idle_en && $urandom_range(0, 1) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  beat_t directed [] = '{
    '{CMD_WRITE, 5'd1, 5'd0, 32'h0000_0000, 32'h0, 32'h0, 0, 0},
    '{CMD_WRITE, 5'd2, 5'd0, 32'h0001_0000, 32'hffff_ffff, 32'hffff_ffff, 0, 0},
    '{CMD_WRITE, 5'd0, 5'd1, 32'h0000_0000, 32'h0, 32'h0, 0, 0},
    '{CMD_WRITE, 5'd0, 5'd2, 32'h0001_0000, 32'h0, 32'h0, 0, 0},
    '{CMD_WRITE, 5'd1, 5'd1, 32'h0064_0000, 32'h0, 32'h0, 0, 0},
    '{CMD_WRITE, 5'd2, 5'd1, 32'h7fff_ffff, 32'h0, 32'h0, 0, 0},
    '{CMD_WRITE, 5'd1, 5'd2, 32'h8000_0000, 32'h0, 32'h0, 0, 0},
    '{CMD_WRITE, 5'd2, 5'd2, 32'h0001_0000, 32'h0, 32'h0, 0, 0},
    '{CMD_WRITE, 5'd31, 5'd31, 32'h7fff_ffff, 32'h0, 32'h0, 0, 0},
    '{CMD_WRITE, 5'd31, 5'd31, 32'h8000_0000, 32'h0, 32'h0, 0, 0},
    '{CMD_QUERY, 5'd31, 5'd31, 32'hffff_ffff, 32'h0, 32'h0, 1, 32'h0064_0000},
    '{CMD_QUERY, 5'd0, 5'd0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 1, 32'h0001_0000},
    '{CMD_QUERY, 5'd0, 5'd0, 32'h0, 32'h0001_0000, 32'h0001_0000, 1, 32'h0001_0000},
    '{CMD_QUERY, 5'd0, 5'd0, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h8000_0000},
    '{CMD_QUERY, 5'd0, 5'd0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 1, 32'h7fff_ffff},
    '{CMD_QUERY, 5'd0, 5'd0, 32'h0, 32'h8000_0000, 32'h8000_0000, 1, 32'h0064_0000},
    '{CMD_QUERY, 5'd0, 5'd0, 32'h0, 32'h0000_8000, 32'h0000_8000, 0, 0},
    '{CMD_QUERY, 5'd0, 5'd0, 32'h0, 32'h0000_4000, 32'h0000_c000, 0, 0},
    '{CMD_QUERY, 5'd0, 5'd0, 32'h0, 32'h0000_0001, 32'h0000_ffff, 0, 0},
    '{CMD_WRITE, 5'd2, 5'd0, 32'h0000_0000, 32'h0, 32'h0, 0, 0},
    '{CMD_QUERY, 5'd0, 5'd0, 32'h0, 32'h0000_8000, 32'h0000_8000, 0, 0}
  };

  initial begin
    int n;
    beat_t b;
    errors = 0;
    items = 0;
    idle_en = 1;
    points_reg = 2;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    cmd_i <= CMD_WRITE;
    row_index_i <= '0;
    column_index_i <= '0;
    table_word_i <= '0;
    query_pressure_i <= '0;
    query_temperature_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) send(directed[k]);

    for (int ph = 0; items < 2000; ph++) begin
      case (ph)
        0: n = 31;
        1: n = 0;
        2: n = 1;
        3: n = 2;
        default: n = ($urandom_range(0, 4) == 0) ? 31 : $urandom_range(2, 8);
      endcase
      if (items > 1700) idle_en = 0;
      set_points(n);
      if (n < 2) n = 2;
      load_axis(0, n);
      load_axis(1, n);
      for (int r = 1; r <= n; r++)
        for (int c = 1; c <= n; c++)
          if (!written[r][c] || $urandom_range(0, 3) == 0)
            put_word(r, c, ($urandom_range(0, 3) == 0) ? $urandom :
                     32'($signed($urandom_range(0, 1 << 24)) - (1 << 23)));
      repeat ($urandom_range(30, 80)) begin
        if ($urandom_range(0, 9) == 0) begin
          put_word($urandom_range(1, n), $urandom_range(1, n), $urandom);
        end else begin
          b = '{CMD_QUERY, 5'($urandom), 5'($urandom), $urandom,
                pick_coord(0, n), pick_coord(1, n), 0, 0};
          send(b);
        end
      end
    end

    in_valid_i <= 1'b0;
    wait (interp_queue.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && interp_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
